// File: rtl/core/selm_pkg.sv
// ----------------------------------------------------------------------------
// selm_pkg
// types and constants shared by the shared/exclusive lock manager modules
// ----------------------------------------------------------------------------
package selm_pkg;

  localparam int unsigned RANK_W  = 8;
  localparam int unsigned COUNT_W = 9;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // operation codes
  localparam logic OP_LOCK   = 1'b0;
  localparam logic OP_UNLOCK = 1'b1;

  // lock kinds
  localparam logic [1:0] KIND_EXCL   = 2'd0;
  localparam logic [1:0] KIND_SHARED = 2'd1;

  // result messages
  localparam logic [1:0] MSG_GRANT       = 2'd0;
  localparam logic [1:0] MSG_REPLY       = 2'd1;
  localparam logic [1:0] MSG_FULL        = 2'd2;
  localparam logic [1:0] MSG_FREE_UNLOCK = 2'd3;

  typedef enum logic [1:0] {
    MODE_FREE   = 2'd0,
    MODE_EXCL   = 2'd1,
    MODE_SHARED = 2'd2
  } selm_mode_e;

  typedef struct packed {
    logic              op;
    logic [RANK_W-1:0] requester;
    logic [1:0]        lock_kind;
  } selm_req_t;

  typedef struct packed {
    logic [1:0]        message;
    logic [RANK_W-1:0] destination;
    logic              last;
  } selm_res_t;

  // one waiting request: kind bit is 1 for shared
  typedef struct packed {
    logic              shared;
    logic [RANK_W-1:0] rank;
  } selm_qentry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } selm_qctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } selm_qstat_t;

endpackage

// File: rtl/core/selm_ram.sv
// ----------------------------------------------------------------------------
// selm_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module selm_ram #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/selm_queue.sv
// ----------------------------------------------------------------------------
// selm_queue
// ring queue of waiting lock requests, entries kept in a ram
// ----------------------------------------------------------------------------
module selm_queue
  import selm_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  selm_qctl_t   ctl_i,
  input  selm_qentry_t push_entry_i,
  output selm_qstat_t  stat_o,
  output selm_qentry_t head_entry_o
);

  localparam int unsigned PtrW  = $clog2(QUEUE_DEPTH);
  localparam int unsigned FillW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0]  PtrLast = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [FillW-1:0] FillMax = FillW'(QUEUE_DEPTH);

  logic [PtrW-1:0]  head_q, head_d;
  logic [PtrW-1:0]  tail_q, tail_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [$bits(selm_qentry_t)-1:0] rdata;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    fill_d = fill_q;
    if (ctl_i.push) begin
      tail_d = (tail_q == PtrLast) ? '0 : tail_q + 1'b1;
    end
    if (ctl_i.pop) begin
      head_d = (head_q == PtrLast) ? '0 : head_q + 1'b1;
    end
    if (ctl_i.push && !ctl_i.pop) begin
      fill_d = fill_q + 1'b1;
    end else if (ctl_i.pop && !ctl_i.push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      fill_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      fill_q <= fill_d;
    end
  end

  // head entry is read on pop and shows up in the cycle after
  selm_ram #(
    .WIDTH ($bits(selm_qentry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.push),
    .waddr_i (tail_q),
    .wdata_i (push_entry_i),
    .re_i    (ctl_i.pop),
    .raddr_i (head_q),
    .rdata_o (rdata)
  );

  assign head_entry_o = selm_qentry_t'(rdata);
  assign stat_o.empty = (fill_q == '0);
  assign stat_o.full  = (fill_q == FillMax);

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.push |-> !stat_o.full)
    else $error("push into full queue");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.pop |-> !stat_o.empty)
    else $error("pop from empty queue");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillMax)
    else $error("queue fill above depth");

endmodule

// File: rtl/core/shared_exclusive_lock_manager_core.sv
// ----------------------------------------------------------------------------
// shared_exclusive_lock_manager_core
// target-side reader/writer lock with a fifo of waiting lock requests
// ----------------------------------------------------------------------------
//
//  channel   | handshake              | payload
//  ----------+------------------------+-------------------------------------
//  request   | start, busy            | req_i : op, requester, lock_kind
//  result    | res_valid_o (strobe)   | res_o : message, destination, last
//
//  for a lock request or a plain unlock, the result (if any) strobes in the
//  cycle after the accepting edge and busy stays low
//  an unlock that frees the lock while requests wait strobes the reply first,
//  then the queued grant once the queue ram read returns
//  reset clears lock mode, holder count and queue pointers; ram contents are
//  left alone since only written entries are ever read
//  the receiver cannot stall, every result is a one-cycle strobe
//
module shared_exclusive_lock_manager_core
  import selm_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned MAX_RANKS   = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  selm_req_t req_i,
  output logic      res_valid_o,
  output selm_res_t res_o
);

  typedef enum logic {
    ST_IDLE,
    ST_GRANT
  } state_e;

  state_e           state_q, state_d;
  selm_mode_e       mode_q, mode_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic             res_valid_q, res_valid_d;
  selm_res_t        res_q, res_d;

  selm_qctl_t       q_ctl;
  selm_qstat_t      q_stat;
  selm_qentry_t     q_push;
  selm_qentry_t     q_head;

  logic             accept;
  logic             rank_ok;
  logic             grant;
  logic             freed;
  logic [COUNT_W-1:0] count_dec;

  assign accept  = start && (state_q == ST_IDLE);
  // ranks at or above the configured count are dropped without a result
  assign rank_ok = (32'(req_i.requester) < 32'(MAX_RANKS));

  assign q_push.shared = (req_i.lock_kind == KIND_SHARED);
  assign q_push.rank   = req_i.requester;

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    count_d     = count_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    q_ctl       = '0;
    grant       = 1'b0;
    freed       = 1'b0;
    count_dec   = (count_q != '0) ? count_q - 1'b1 : '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept && rank_ok) begin
          res_d.destination = req_i.requester;
          res_d.last        = 1'b1;
          if (req_i.op == OP_LOCK) begin
            if (req_i.lock_kind == KIND_EXCL || req_i.lock_kind == KIND_SHARED) begin
              if (req_i.lock_kind == KIND_EXCL) begin
                grant = (mode_q == MODE_FREE);
                if (grant) begin
                  mode_d = MODE_EXCL;
                end
              end else begin
                grant = (mode_q != MODE_EXCL);
                if (grant) begin
                  mode_d = MODE_SHARED;
                  // holder count saturates at its top value
                  if (count_q != COUNT_MAX) begin
                    count_d = count_q + 1'b1;
                  end
                end
              end
              if (grant) begin
                res_valid_d   = 1'b1;
                res_d.message = MSG_GRANT;
              end else if (q_stat.full) begin
                res_valid_d   = 1'b1;
                res_d.message = MSG_FULL;
              end else begin
                q_ctl.push = 1'b1;
              end
            end
          end else begin
            if (mode_q == MODE_FREE) begin
              res_valid_d   = 1'b1;
              res_d.message = MSG_FREE_UNLOCK;
            end else begin
              if (mode_q == MODE_SHARED) begin
                count_d = count_dec;
                freed   = (count_dec == '0);
                mode_d  = freed ? MODE_FREE : MODE_SHARED;
              end else begin
                // exclusive, and the unused code handled the same way
                freed  = 1'b1;
                mode_d = MODE_FREE;
              end
              res_valid_d   = 1'b1;
              res_d.message = MSG_REPLY;
              // lock went free with requests waiting: read the head entry
              if (freed && !q_stat.empty) begin
                q_ctl.pop  = 1'b1;
                res_d.last = 1'b0;
                state_d    = ST_GRANT;
              end
            end
          end
        end
      end
      ST_GRANT: begin
        // ram read data holds the popped request
        res_valid_d       = 1'b1;
        res_d.message     = MSG_GRANT;
        res_d.destination = q_head.rank;
        res_d.last        = 1'b1;
        if (q_head.shared) begin
          mode_d  = MODE_SHARED;
          count_d = COUNT_W'(1);
        end else begin
          mode_d = MODE_EXCL;
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_FREE;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  // result payload needs no reset, it is qualified by the strobe
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  selm_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (q_ctl),
    .push_entry_i (q_push),
    .stat_o       (q_stat),
    .head_entry_o (q_head)
  );

  assign busy        = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // a reply marked not-last is always followed by the queued grant
  a_reply_then_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_q.last) |=> (res_valid_q && res_q.last &&
                                      res_q.message == MSG_GRANT))
    else $error("non-last result not followed by grant");

  // holders are only counted while the lock is shared
  a_count_only_shared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != MODE_SHARED) |-> (count_q == '0))
    else $error("holder count nonzero outside shared mode");

  // the grant cycle is entered only from an unlock that freed the lock
  a_grant_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_ctl.pop |-> (mode_d == MODE_FREE && state_d == ST_GRANT))
    else $error("queue popped while lock not free");

  a_no_accept_in_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GRANT) |-> (q_ctl == '0))
    else $error("queue access during grant cycle");

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for shared_exclusive_lock_manager_core: drives lock and
// unlock requests through the start/busy handshake, predicts every grant,
// reply and reject from its own lock and wait-queue state, and checks each
// strobed result against the oldest pending prediction
// ----------------------------------------------------------------------------
module tb;
  import selm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned MAX_RANKS   = 256;
  localparam int unsigned REQ_W       = $bits(selm_req_t);

  // dut signals, all inputs known from time zero
  logic      clk_i  = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start  = 1'b0;
  logic      busy;
  selm_req_t req_i  = '0;
  logic      res_valid_o;
  selm_res_t res_o;

  // predicted lock state
  selm_mode_e         lock_mode;
  logic [COUNT_W-1:0] holder_count;
  selm_qentry_t       waiting_list[$];

  // predicted results, oldest first
  selm_res_t expected_msgs[$];

  // sender controls idle bursts between transactions
  bit gaps_on;

  // run statistics
  int mismatch_count;
  int sent_count;
  int ignored_count;
  int results_seen[4];

  shared_exclusive_lock_manager_core #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .MAX_RANKS  (MAX_RANKS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // lock predictor: updates the shadow state for one accepted transaction and
  // queues whatever results the block must strobe for it
  // --------------------------------------------------------------------------
  function automatic void predict_lock_response(selm_req_t r);
    logic         granted;
    selm_qentry_t head;
    if (r.op == OP_LOCK) begin
      if (r.lock_kind == KIND_EXCL) begin
        // exclusive only on a free lock
        granted = (lock_mode == MODE_FREE);
        if (granted) lock_mode = MODE_EXCL;
      end else if (r.lock_kind == KIND_SHARED) begin
        // shared joins unless held exclusively, even with writers waiting
        granted = (lock_mode != MODE_EXCL);
        if (granted) begin
          lock_mode = MODE_SHARED;
          if (holder_count != COUNT_MAX) holder_count++;
        end
      end else begin
        // invalid kind: silently dropped, no state change
        return;
      end
      if (granted) begin
        expected_msgs.push_back(selm_res_t'{message: MSG_GRANT,
                                            destination: r.requester, last: 1'b1});
      end else if (waiting_list.size() >= QUEUE_DEPTH) begin
        expected_msgs.push_back(selm_res_t'{message: MSG_FULL,
                                            destination: r.requester, last: 1'b1});
      end else begin
        waiting_list.push_back(selm_qentry_t'{shared: (r.lock_kind == KIND_SHARED),
                                              rank: r.requester});
      end
      return;
    end

    // unlock on a free lock is flagged and changes nothing
    if (lock_mode == MODE_FREE) begin
      expected_msgs.push_back(selm_res_t'{message: MSG_FREE_UNLOCK,
                                          destination: r.requester, last: 1'b1});
      return;
    end

    // release one hold; an unused mode code would behave as exclusive
    if (lock_mode == MODE_SHARED) begin
      if (holder_count != '0) holder_count--;
      if (holder_count == '0) lock_mode = MODE_FREE;
    end else begin
      lock_mode = MODE_FREE;
    end

    // lock just went free: hand it to the oldest waiter, at most one per unlock
    if (lock_mode == MODE_FREE && waiting_list.size() != 0) begin
      head = waiting_list.pop_front();
      if (head.shared) begin
        lock_mode    = MODE_SHARED;
        holder_count = COUNT_W'(1);
      end else begin
        lock_mode = MODE_EXCL;
      end
      expected_msgs.push_back(selm_res_t'{message: MSG_REPLY,
                                          destination: r.requester, last: 1'b0});
      expected_msgs.push_back(selm_res_t'{message: MSG_GRANT,
                                          destination: head.rank, last: 1'b1});
    end else begin
      expected_msgs.push_back(selm_res_t'{message: MSG_REPLY,
                                          destination: r.requester, last: 1'b1});
    end
  endfunction

  // --------------------------------------------------------------------------
  // result checker: every strobe is one result and must match the oldest
  // prediction field by field
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    selm_res_t want;
    if (rst_ni && res_valid_o) begin
      results_seen[res_o.message]++;
      if (expected_msgs.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 100)
          $display({"%0t: unexpected result: expected none, ",
                    "actual msg=%0d dest=%0d last=%0b"},
                   $time, res_o.message, res_o.destination, res_o.last);
      end else begin
        want = expected_msgs.pop_front();
        if (res_o.message !== want.message || res_o.destination !== want.destination ||
            res_o.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 100)
            $display({"%0t: result mismatch: expected msg=%0d dest=%0d last=%0b, ",
                      "actual msg=%0d dest=%0d last=%0b"},
                     $time, want.message, want.destination, want.last,
                     res_o.message, res_o.destination, res_o.last);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // request driver: called and returns at a falling edge; start stays high
  // between back-to-back transactions and is only lowered for an idle burst
  // --------------------------------------------------------------------------
  task automatic send_request(logic op, logic [RANK_W-1:0] rank, logic [1:0] kind);
    selm_req_t r;
    int        gap;
    r.op        = op;
    r.requester = rank;
    r.lock_kind = kind;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap   = $urandom_range(1, 12);
      start = 1'b0;
      // junk on the payload while idle must be ignored
      req_i = selm_req_t'(REQ_W'($urandom));
      repeat (gap) @(negedge clk_i);
    end
    start = 1'b1;
    req_i = r;
    // transaction taken at the first rising edge with busy low
    do @(posedge clk_i); while (busy);
    predict_lock_response(r);
    sent_count++;
    if (op == OP_LOCK && kind != KIND_EXCL && kind != KIND_SHARED) ignored_count++;
    @(negedge clk_i);
  endtask

  // hold off until every predicted result has arrived, plus the block's latency
  task automatic wait_for_results();
    start = 1'b0;
    while (expected_msgs.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // directed tests
  // --------------------------------------------------------------------------

  // unlock on a free lock, lowest and highest rank, kind field ignored
  task automatic test_unlock_while_free();
    send_request(OP_UNLOCK, 8'd0, 2'd3);
    send_request(OP_UNLOCK, 8'd255, KIND_EXCL);
  endtask

  // lock kinds 2 and 3 produce nothing, whether free or held
  task automatic test_invalid_kind();
    send_request(OP_LOCK, 8'd255, 2'd2);
    send_request(OP_LOCK, 8'd0, 2'd3);
    send_request(OP_LOCK, 8'd7, KIND_EXCL);
    send_request(OP_LOCK, 8'd8, 2'd3);
    send_request(OP_UNLOCK, 8'd7, 2'd2);
  endtask

  // exclusive/shared interplay: queuing, pop on free, shared grant past a
  // waiting writer, shared pop resetting the count to one
  task automatic test_exclusive_and_shared();
    send_request(OP_LOCK, 8'd1, KIND_EXCL);
    send_request(OP_LOCK, 8'd2, KIND_SHARED);
    send_request(OP_LOCK, 8'd3, KIND_EXCL);
    send_request(OP_UNLOCK, 8'd1, KIND_SHARED);
    send_request(OP_LOCK, 8'd4, KIND_SHARED);
    send_request(OP_UNLOCK, 8'd2, KIND_EXCL);
    send_request(OP_UNLOCK, 8'd4, KIND_EXCL);
    send_request(OP_UNLOCK, 8'd3, KIND_EXCL);
  endtask

  // fill the wait queue to its depth, then one more lock is rejected
  task automatic test_queue_full();
    send_request(OP_LOCK, 8'd10, KIND_EXCL);
    repeat (QUEUE_DEPTH)
      send_request(OP_LOCK, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 1)));
    send_request(OP_LOCK, 8'd170, KIND_SHARED);
  endtask

  // --------------------------------------------------------------------------
  // random traffic: mostly valid locks and unlocks with random ranks, a little
  // noise from invalid kinds that is not counted toward the item total
  // --------------------------------------------------------------------------
  task automatic test_random_mix(int items, int lock_pct);
    int done;
    int pick;
    done = 0;
    while (done < items) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        send_request(OP_LOCK, 8'($urandom_range(0, 255)), 2'($urandom_range(2, 3)));
      end else if (pick < 5 + lock_pct) begin
        send_request(OP_LOCK, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 1)));
        done++;
      end else begin
        send_request(OP_UNLOCK, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
        done++;
      end
    end
  endtask

  // sender pauses mid-run until the block has delivered everything
  task automatic test_drain_pause();
    wait_for_results();
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    lock_mode    = MODE_FREE;
    holder_count = '0;
    gaps_on      = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_unlock_while_free();
    test_invalid_kind();
    test_exclusive_and_shared();
    test_queue_full();

    gaps_on = 1'b1;
    test_random_mix(90, 70);
    test_drain_pause();
    test_random_mix(90, 25);
    test_random_mix(90, 50);

    // closing stretch runs back to back
    gaps_on = 1'b0;
    test_random_mix(90, 50);

    wait_for_results();

    $display({"covered %0d request transactions (%0d with invalid lock kind), ",
              "incl. queue overflow and queued shared grants"},
             sent_count, ignored_count);
    $display({"results checked: %0d grants, %0d unlock replies, ",
              "%0d queue-full rejects, %0d unlocks while free"},
             results_seen[MSG_GRANT], results_seen[MSG_REPLY], results_seen[MSG_FULL],
             results_seen[MSG_FREE_UNLOCK]);
    if (mismatch_count == 0) begin
      $display("** shared_exclusive_lock_manager_core: PASSED **");
    end else begin
      $display("** shared_exclusive_lock_manager_core: FAILED **");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5ms;
    $display("timeout waiting for the block");
    $display("** shared_exclusive_lock_manager_core: FAILED **");
    $finish;
  end

endmodule
